>>> src/lcdsw_pkg.sv
`default_nettype none
package lcdsw_pkg;

    // Shadow geometry
    localparam int SEG_COUNT = 32;
    localparam int SEG_AW    = (SEG_COUNT > 1) ? $clog2(SEG_COUNT) : 1;

    // Request kinds
    localparam logic [2:0] REQ_SEGWR   = 3'd0;
    localparam logic [2:0] REQ_REFRESH = 3'd1;
    localparam logic [2:0] REQ_CMD     = 3'd2;
    localparam logic [2:0] REQ_CLEAR   = 3'd3;
    localparam logic [2:0] REQ_FILL    = 3'd4;

    // Frame constants, first bit on the wire in bit 0
    localparam logic [11:0] HDR_WRITE_BITS = 12'h005;
    localparam logic [2:0]  HDR_CMD_ID     = 3'b001;
    localparam logic [3:0]  HDR_WRITE_LEN  = 4'd9;
    localparam logic [3:0]  CMD_LEN        = 4'd12;
    localparam logic [3:0]  DATA_LEN       = 4'd8;

    typedef struct packed {
        logic [2:0] req_type;
        logic [4:0] segment_index;
        logic [2:0] bit_row;
        logic       segment_value;
        logic [7:0] cmd_code;
    } t_request;

    typedef struct packed {
        logic [11:0] chunk_bits;
        logic [3:0]  chunk_len;
        logic        last;
    } t_result;

    // Microprogram addresses
    typedef logic [2:0] t_upc;
    localparam t_upc UPC_IDLE  = 3'd0;
    localparam t_upc UPC_SEGWR = 3'd1;
    localparam t_upc UPC_CMD   = 3'd2;
    localparam t_upc UPC_CLEAR = 3'd3;
    localparam t_upc UPC_FILL  = 3'd4;
    localparam t_upc UPC_HDR   = 3'd5;
    localparam t_upc UPC_DATA  = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_SEGWR = 3'd1,
        OP_CMD   = 3'd2,
        OP_HDR   = 3'd3,
        OP_DATA  = 3'd4
    } t_dp_op;

    typedef enum logic [1:0] {
        FILL_NONE = 2'd0,
        FILL_ZERO = 2'd1,
        FILL_ONES = 2'd2
    } t_fill;

    typedef enum logic [1:0] {
        J_GOTO     = 2'd0,
        J_DISPATCH = 2'd1,
        J_LOOP     = 2'd2
    } t_jump;

    typedef struct packed {
        t_jump  jump;
        t_upc   target;
        t_dp_op op;
        t_fill  fill;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic   accept;
        t_dp_op op;
        t_fill  fill;
    } t_dp_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic ptr_last;
    } t_dp_stat;

    // Control store
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        case (pc)
            UPC_IDLE:  w = '{jump: J_DISPATCH, target: UPC_IDLE, op: OP_NOP,   fill: FILL_NONE};
            UPC_SEGWR: w = '{jump: J_GOTO,     target: UPC_IDLE, op: OP_SEGWR, fill: FILL_NONE};
            UPC_CMD:   w = '{jump: J_GOTO,     target: UPC_IDLE, op: OP_CMD,   fill: FILL_NONE};
            UPC_CLEAR: w = '{jump: J_GOTO,     target: UPC_DATA, op: OP_HDR,   fill: FILL_ZERO};
            UPC_FILL:  w = '{jump: J_GOTO,     target: UPC_DATA, op: OP_HDR,   fill: FILL_ONES};
            UPC_HDR:   w = '{jump: J_GOTO,     target: UPC_DATA, op: OP_HDR,   fill: FILL_NONE};
            UPC_DATA:  w = '{jump: J_LOOP,     target: UPC_IDLE, op: OP_DATA,  fill: FILL_NONE};
            default:   w = '{jump: J_GOTO,     target: UPC_IDLE, op: OP_NOP,   fill: FILL_NONE};
        endcase
        return w;
    endfunction

    // Entry point of each request kind; unknown kinds stay idle
    function automatic t_upc dispatch_entry(input logic [2:0] req_type);
        t_upc pc;
        case (req_type)
            REQ_SEGWR:   pc = UPC_SEGWR;
            REQ_REFRESH: pc = UPC_HDR;
            REQ_CMD:     pc = UPC_CMD;
            REQ_CLEAR:   pc = UPC_CLEAR;
            REQ_FILL:    pc = UPC_FILL;
            default:     pc = UPC_IDLE;
        endcase
        return pc;
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/segment_lcd_shadow_ram_writer.sv
// Shadow of a segment LCD display memory with three-wire write frame builder.
// Input: a request is transferred at a rising edge where start is high and
// busy is low. Kinds: segment write, refresh, command, clear all, fill all.
// Output: each chunk sits on o_result for one cycle with o_strobe high; the
// receiver takes it at the end of that cycle and cannot hold it off.
// Each request's entry step is loaded into the step counter at the transfer,
// and each chunk is registered out of its step. A refresh, clear or fill
// keeps busy high through one header step, then one step per shadow byte, the
// data step reading one byte per cycle. A command keeps busy high for one
// cycle and gives one chunk; a segment write keeps busy high for one cycle
// and gives none. Unknown kinds are transferred and dropped, busy stays low.
// Chip select is to be released after the chunk with last set.
// Reset: the shadow is cleared to zero and the sequencer returns to idle;
// no strobe is issued while reset is held.
`default_nettype none
module segment_lcd_shadow_ram_writer
    import lcdsw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_request i_req,
    output t_result       o_result,
    output logic          o_strobe
);

    logic     w_accept;
    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    assign w_accept = start && !busy;

    // Microprogram sequencer
    lcdsw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req_type (i_req.req_type),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_busy     (busy)
    );

    // Shadow and chunk datapath
    lcdsw_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_ctrl   (w_ctrl),
        .o_stat   (w_stat),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

`ifndef SYNTHESIS
    a_cmd_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == REQ_CMD) |-> ##2
        (o_strobe && o_result.chunk_len == CMD_LEN && o_result.last))
        else $error("command chunk not issued two cycles after transfer");

    a_refresh_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == REQ_REFRESH) |-> ##2
        (o_strobe && o_result.chunk_len == HDR_WRITE_LEN))
        else $error("refresh header not issued two cycles after transfer");

    a_hdr_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.chunk_len == HDR_WRITE_LEN) |=>
        (o_strobe && o_result.chunk_len == DATA_LEN))
        else $error("header chunk not followed by a data chunk");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !o_strobe)
        else $error("chunk issued directly after end of frame");

    a_segwr_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == REQ_SEGWR) |=> (busy ##1 !busy))
        else $error("segment write did not finish in one step");
`endif

endmodule
`default_nettype wire

>>> src/lcdsw_seq.sv
`default_nettype none
module lcdsw_seq
    import lcdsw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [2:0] i_req_type,
    input  wire t_dp_stat   i_stat,
    output t_dp_ctrl        o_ctrl,
    output logic            o_busy
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_uword;

    // Fetch the current control word
    assign w_uword = ucode_rom(r_upc);

    // Select the next step
    always_comb begin
        case (w_uword.jump)
            J_GOTO:     n_upc = w_uword.target;
            J_DISPATCH: n_upc = i_accept ? dispatch_entry(i_req_type) : r_upc;
            J_LOOP:     n_upc = i_stat.ptr_last ? w_uword.target : r_upc;
            default:    n_upc = UPC_IDLE;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_busy        = (r_upc != UPC_IDLE);
    assign o_ctrl.accept = i_accept;
    assign o_ctrl.op     = w_uword.op;
    assign o_ctrl.fill   = w_uword.fill;

endmodule
`default_nettype wire

>>> src/lcdsw_dp.sv
`default_nettype none
module lcdsw_dp
    import lcdsw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_request i_req,
    input  wire t_dp_ctrl i_ctrl,
    output t_dp_stat      o_stat,
    output t_result       o_result,
    output logic          o_strobe
);

    t_request          r_req;
    logic [7:0]        r_shadow [SEG_COUNT];
    logic [SEG_AW-1:0] r_ptr;
    t_result           r_result;
    logic              r_strobe;
    logic              w_seg_ok;
    logic              w_ptr_last;
    logic [SEG_AW-1:0] w_seg_idx;

    assign w_seg_ok   = ({1'b0, r_req.segment_index} < 6'(SEG_COUNT));
    assign w_seg_idx  = r_req.segment_index[SEG_AW-1:0];
    assign w_ptr_last = (r_ptr == SEG_AW'(SEG_COUNT - 1));

    // Hold the request for the steps that follow the transfer
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_req <= i_req;
        end
    end

    // Shadow update: single bit, or fill of every byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SEG_COUNT; i++) begin
                r_shadow[i] <= 8'h00;
            end
        end else begin
            case (i_ctrl.fill)
                FILL_ZERO: begin
                    for (int i = 0; i < SEG_COUNT; i++) begin
                        r_shadow[i] <= 8'h00;
                    end
                end
                FILL_ONES: begin
                    for (int i = 0; i < SEG_COUNT; i++) begin
                        r_shadow[i] <= 8'hff;
                    end
                end
                default: begin
                    if (i_ctrl.op == OP_SEGWR && w_seg_ok) begin
                        r_shadow[w_seg_idx][r_req.bit_row] <= r_req.segment_value;
                    end
                end
            endcase
        end
    end

    // Walk the shadow pointer over the data chunks
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_HDR:  r_ptr <= '0;
            OP_DATA: r_ptr <= r_ptr + 1'b1;
            default: r_ptr <= r_ptr;
        endcase
    end

    // Build the chunk for this step
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_CMD: begin
                r_result <= '{chunk_bits: {1'b0, reverse8(r_req.cmd_code), HDR_CMD_ID},
                              chunk_len: CMD_LEN, last: 1'b1};
            end
            OP_HDR: begin
                r_result <= '{chunk_bits: HDR_WRITE_BITS, chunk_len: HDR_WRITE_LEN,
                              last: 1'b0};
            end
            OP_DATA: begin
                r_result <= '{chunk_bits: {4'b0000, r_shadow[r_ptr]}, chunk_len: DATA_LEN,
                              last: w_ptr_last};
            end
            default: r_result <= r_result;
        endcase
    end

    // Strobe each chunk for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_ctrl.op == OP_CMD) || (i_ctrl.op == OP_HDR)
                        || (i_ctrl.op == OP_DATA);
        end
    end

    assign o_stat.ptr_last = w_ptr_last;
    assign o_result        = r_result;
    assign o_strobe        = r_strobe;

endmodule
`default_nettype wire
